@@ design/pobau_pkg.sv @@
// Shared types and codes for the power-of-two block allocator.
package pobau_pkg;

   typedef enum logic [1:0] {
      REQ_ALLOC      = 2'd0,
      REQ_FREE       = 2'd1,
      REQ_FREE_OWNER = 2'd2,
      REQ_UNKNOWN    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_LARGE  = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] request_size;
      logic [31:0] block_address;
      logic [7:0]  owner_id;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] granted_address;
      logic [31:0] granted_size;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_CAND,
      S_SCAN,
      S_SCAN_CHK,
      S_NEXT_CAND,
      S_SLOT,
      S_SLOT_CHK,
      S_WRITE,
      S_FREE_SCAN,
      S_FREE_CHK,
      S_RESP
   } state_type;

   localparam logic [1:0] CSR_ALLOC_BASE = 2'd0;
   localparam logic [1:0] CSR_POOL_END   = 2'd1;
   localparam logic [1:0] CSR_MAX_SIZE   = 2'd2;

endpackage

@@ design/pobau_ram.sv @@
// Generic single-port RAM with registered read.
module pobau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

@@ design/power_of_two_block_allocator_unit.sv @@
// Top level of the power-of-two block allocator: registers, sequencer and record table.
// Rounding steps through powers of two; each address probe reads the records one by one
// through one RAM read port and one shared overlap comparator, and a granted block adds a
// slot search over the records; frees scan the records one by one.
// Throughput: one item at a time; a new item is taken once the result beat has left.
// Reset (synchronous) clears the CSR registers, the state and all record valid bits at once.
module power_of_two_block_allocator_unit
   import pobau_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int PAGE_BYTES    = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
   localparam int IW = $clog2(TABLE_ENTRIES);

   logic [31:0] base_ff, end_ff, max_ff;
   state_type state_ff, state_in;
   req_payload_type req_ff;
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [5:0] shift_ff, shift_in;
   logic [32:0] size_ff, size_in;
   logic [33:0] addr_ff, addr_in;
   logic [33:0] mult_ff, mult_in;
   logic second_ff, second_in;
   logic [2:0] status_ff, status_in;
   logic [31:0] gaddr_ff, gaddr_in, gsize_ff, gsize_in;
   logic rsp_valid_ff;

   logic [71:0] ram_rd;
   logic ram_we;
   logic [31:0] e_start, e_size;
   logic [7:0] e_owner;
   logic [34:0] e_end, c_end;
   logic hit_ovl, hit_in_blk, last_idx;
   logic [32:0] pow_val, round_val;
   logic round_done;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         end_ff  <= '0;
         max_ff  <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            CSR_ALLOC_BASE: base_ff <= csr_pwdata;
            CSR_POOL_END:   end_ff  <= csr_pwdata;
            CSR_MAX_SIZE:   max_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_ALLOC_BASE: csr_prdata = base_ff;
         CSR_POOL_END:   csr_prdata = end_ff;
         CSR_MAX_SIZE:   csr_prdata = max_ff;
         default:        csr_prdata = '0;
      endcase
   end

   pobau_ram #(.WIDTH(72), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (idx_ff),
      .wr_data ({addr_ff[31:0], size_ff[31:0], req_ff.owner_id}),
      .rd_data (ram_rd)
   );

   assign e_start = ram_rd[71:40];
   assign e_size  = ram_rd[39:8];
   assign e_owner = ram_rd[7:0];
   assign e_end = {3'b0, e_start} + {3'b0, e_size};
   assign c_end = {1'b0, addr_ff} + {2'b0, size_ff};
   assign hit_ovl = used_ff[idx_ff] && ({3'b0, e_start} < c_end)
                    && ({1'b0, addr_ff} < e_end);
   assign hit_in_blk = used_ff[idx_ff] && (e_start <= req_ff.block_address)
                       && ({3'b0, req_ff.block_address} < e_end);
   assign last_idx = (idx_ff == IW'(TABLE_ENTRIES - 1));
   assign ram_we = (state_ff == S_WRITE);
   assign pow_val = 33'(1) << shift_ff;
   assign round_val = (size_ff == '0) ? '0 : pow_val;
   assign round_done = (size_ff == '0) || (pow_val >= size_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            state_in = (req_payload.req_type == REQ_ALLOC) ? S_ROUND :
                       (req_payload.req_type == REQ_UNKNOWN) ? S_RESP : S_FREE_SCAN;
         end
         S_ROUND: begin
            if (round_done) state_in = (round_val > {1'b0, max_ff}) ? S_RESP : S_CAND;
            else state_in = S_ROUND;
         end
         S_CAND: state_in = S_NEXT_CAND;
         S_NEXT_CAND: state_in = ({1'b0, addr_ff} + {2'b0, size_ff} > {3'b0, end_ff})
                                 ? S_RESP : S_SCAN;
         S_SCAN: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (hit_ovl) state_in = S_NEXT_CAND;
            else if (last_idx) state_in = S_SLOT;
            else state_in = S_SCAN;
         end
         S_SLOT: state_in = !used_ff[idx_ff] ? S_WRITE : last_idx ? S_RESP : S_SLOT;
         S_SLOT_CHK: state_in = S_SLOT;
         S_WRITE: state_in = S_RESP;
         S_FREE_SCAN: state_in = S_FREE_CHK;
         S_FREE_CHK: state_in = (req_ff.req_type == REQ_FREE && hit_in_blk) || last_idx
                                ? S_RESP : S_FREE_SCAN;
         S_RESP: if (rsp_valid_ff && rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      shift_in = shift_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      mult_in = mult_ff;
      second_in = second_ff;
      status_in = status_ff;
      gaddr_in = gaddr_ff;
      gsize_in = gsize_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = IW'(1);
            shift_in = '0;
            size_in = {1'b0, req_payload.request_size};
            gaddr_in = '0;
            gsize_in = '0;
            status_in = (req_payload.req_type == REQ_UNKNOWN) ? ST_NOT_FOUND :
                        (req_payload.req_type == REQ_FREE) ? ST_NOT_FOUND : ST_OK;
         end
         S_ROUND: begin
            if (round_done) begin
               if (round_val > {1'b0, max_ff}) status_in = ST_TOO_LARGE;
               else size_in = (round_val < 33'(PAGE_BYTES)) ? 33'(PAGE_BYTES) : round_val;
            end else begin
               shift_in = shift_ff + 6'd1;
            end
         end
         S_CAND: begin
            gsize_in = size_ff[31:0];
            mult_in = {1'b0, size_ff};
            addr_in = {2'b0, base_ff} + {1'b0, size_ff};
            second_in = 1'b0;
         end
         S_NEXT_CAND: begin
            idx_in = IW'(1);
            if ({1'b0, addr_ff} + {2'b0, size_ff} > {3'b0, end_ff})
               status_in = ST_NO_SPACE;
         end
         S_SCAN_CHK: begin
            if (hit_ovl) begin
               if (!second_ff && mult_ff != {1'b0, size_ff}
                   && {1'b0, e_size} <= size_ff) begin
                  addr_in = addr_ff + {1'b0, size_ff};
                  second_in = 1'b1;
               end else begin
                  mult_in = {mult_ff[32:0], 1'b0};
                  addr_in = {2'b0, base_ff} + {mult_ff[32:0], 1'b0};
                  second_in = 1'b0;
               end
            end else if (last_idx) begin
               idx_in = IW'(1);
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_SLOT: begin
            if (!used_ff[idx_ff]) gaddr_in = addr_ff[31:0];
            else if (last_idx) status_in = ST_TABLE_FULL;
            else idx_in = idx_ff + IW'(1);
         end
         S_FREE_CHK: begin
            if (req_ff.req_type == REQ_FREE && hit_in_blk) status_in = ST_OK;
            else if (!last_idx) idx_in = idx_ff + IW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_in == S_RESP) && !(rsp_valid_ff && rsp_ready);
         if (state_ff == S_WRITE) used_ff[idx_ff] <= 1'b1;
         if (state_ff == S_FREE_CHK) begin
            if (req_ff.req_type == REQ_FREE && hit_in_blk) used_ff[idx_ff] <= 1'b0;
            if (req_ff.req_type == REQ_FREE_OWNER && used_ff[idx_ff]
                && e_owner == req_ff.owner_id)
               used_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_payload;
      idx_ff <= idx_in;
      shift_ff <= shift_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      mult_ff <= mult_in;
      second_ff <= second_in;
      status_ff <= status_in;
      gaddr_ff <= gaddr_in;
      gsize_ff <= gsize_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = '{status: status_ff, granted_address: gaddr_ff,
                          granted_size: gsize_ff};
endmodule
